// File: src/zcdp_pkg.sv
package zcdp_pkg;

    localparam logic [31:0] DIR_SIGNATURE = 32'h0201_4b50;

    // fixed part of a directory record, in bytes
    localparam int unsigned FIXED_LEN = 42;
    localparam int unsigned SIG_LEN   = 4;

    // only the fixed-record bytes that feed a field or the skip length are kept
    localparam int unsigned SLOT_CNT  = 32;
    localparam int unsigned SLOT_W    = $clog2(SLOT_CNT);

    typedef enum logic [0:0] {
        KIND_RECORD = 1'b0,
        KIND_END    = 1'b1
    } kind_t;

    typedef enum logic [3:0] {
        PH_SIG   = 4'b0001,
        PH_FIXED = 4'b0010,
        PH_SKIP  = 4'b0100,
        PH_END   = 4'b1000
    } phase_t;

endpackage

// File: src/zip_central_directory_parser.sv
// Zip central directory parser.
// Input channel: one word per byte of the central directory (data_byte),
// with restart marking the first byte of a new directory. Handshake is
// in_valid / in_ready. Output channel: one word per record summary or one
// end word (kind = KIND_END) when a non-matching signature closes the
// directory; handshake is out_valid / out_ready.
// Throughput: one byte per cycle unless a waiting output word holds in_ready low.
// Every byte is parsed in the cycle it is accepted; a byte that completes a record
// or a mismatched signature loads the output register, seen in the next cycle.
// The output register is the only buffer: while it holds a word the receiver
// has not taken, in_ready follows out_ready, and a byte is taken in the same
// cycle the waiting word leaves.
// Reset clears the parser to signature collection with the record index at
// zero and empties the output register. Only the fixed-record bytes that feed
// a field or the skip length are kept (32 bytes), each written before any read.
// After an end word, bytes are dropped until a byte with restart set.
module zip_central_directory_parser
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        restart,

    output logic        out_valid,
    input  logic        out_ready,
    output logic        kind,
    output logic [15:0] min_version,
    output logic [15:0] flag_bits,
    output logic [15:0] method,
    output logic [15:0] mod_time,
    output logic [15:0] mod_date,
    output logic [31:0] crc_value,
    output logic [31:0] packed_size,
    output logic [31:0] plain_size,
    output logic [15:0] name_len,
    output logic [31:0] header_offset,
    output logic [15:0] record_index
);
    import zcdp_pkg::*;

    localparam logic [5:0] SIG_LAST   = 6'(SIG_LEN - 1);
    localparam logic [5:0] FIXED_LAST = 6'(FIXED_LEN - 1);

    phase_t       phase_reg, phase_next, phase_eff;
    logic [5:0]   cnt_reg, cnt_next, cnt_eff;
    logic [31:0]  shift_reg, shift_next, shift_eff;
    logic [17:0]  skip_reg, skip_next, skip_eff;
    logic [15:0]  ctr_reg, ctr_next, ctr_eff;

    logic [7:0]   slot_reg [SLOT_CNT];
    logic [7:0]   view [SLOT_CNT];
    logic         slot_we;
    logic [SLOT_W-1:0] slot_idx;

    logic         accept;
    logic         emit_rec, emit_end;
    logic [17:0]  skip_sum;

    logic         out_valid_reg;
    logic         kind_reg;
    logic [15:0]  min_version_reg, flag_bits_reg, method_reg, mod_time_reg, mod_date_reg;
    logic [31:0]  crc_value_reg, packed_size_reg, plain_size_reg, header_offset_reg;
    logic [15:0]  name_len_reg, record_index_reg;

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    // restart acts on the same byte it arrives with
    always_comb
    begin
        phase_eff = restart ? PH_SIG : phase_reg;
        cnt_eff   = restart ? 6'd0   : cnt_reg;
        shift_eff = restart ? 32'd0  : shift_reg;
        skip_eff  = restart ? 18'd0  : skip_reg;
        ctr_eff   = restart ? 16'd0  : ctr_reg;
    end

    // map fixed-record byte position to a storage slot
    always_comb
    begin
        slot_we  = 1'b0;
        slot_idx = '0;
        if (phase_eff == PH_FIXED)
        begin
            if (cnt_eff >= 6'd2 && cnt_eff <= 6'd29)
            begin
                slot_we  = 1'b1;
                slot_idx = SLOT_W'(cnt_eff - 6'd2);
            end
            else if (cnt_eff >= 6'd38 && cnt_eff <= FIXED_LAST)
            begin
                slot_we  = 1'b1;
                slot_idx = SLOT_W'(cnt_eff - 6'd10);
            end
        end
    end

    // stored bytes with the current byte forwarded
    always_comb
    begin
        for (int i = 0; i < SLOT_CNT; i++)
        begin
            view[i] = slot_reg[i];
        end
        if (slot_we)
        begin
            view[slot_idx] = data_byte;
        end
    end

    // name + extra + comment lengths (record bytes 24..29)
    assign skip_sum = 18'({view[23], view[22]}) + 18'({view[25], view[24]})
                    + 18'({view[27], view[26]});

    always_comb
    begin
        phase_next = phase_eff;
        cnt_next   = cnt_eff;
        shift_next = shift_eff;
        skip_next  = skip_eff;
        ctr_next   = ctr_eff;
        emit_rec   = 1'b0;
        emit_end   = 1'b0;

        unique case (phase_eff)
            PH_SIG:
            begin
                shift_next = {data_byte, shift_eff[31:8]};
                cnt_next   = cnt_eff + 6'd1;
                if (cnt_eff == SIG_LAST)
                begin
                    cnt_next = '0;
                    if (shift_next == DIR_SIGNATURE)
                    begin
                        phase_next = PH_FIXED;
                    end
                    else
                    begin
                        phase_next = PH_END;
                        emit_end   = 1'b1;
                    end
                end
            end
            PH_FIXED:
            begin
                cnt_next = cnt_eff + 6'd1;
                if (cnt_eff == FIXED_LAST)
                begin
                    cnt_next  = '0;
                    skip_next = skip_sum;
                    if (skip_sum == '0)
                    begin
                        emit_rec = 1'b1;
                    end
                    else
                    begin
                        phase_next = PH_SKIP;
                    end
                end
            end
            PH_SKIP:
            begin
                skip_next = (skip_eff != '0) ? skip_eff - 18'd1 : '0;
                if (skip_next == '0)
                begin
                    emit_rec = 1'b1;
                end
            end
            PH_END:
            begin
                phase_next = PH_END;
            end
            default:
            begin
                phase_next = PH_SIG;
            end
        endcase

        if (emit_rec)
        begin
            phase_next = PH_SIG;
            cnt_next   = '0;
            shift_next = '0;
            if (ctr_eff != 16'hFFFF)
            begin
                ctr_next = ctr_eff + 16'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_SIG;
            cnt_reg   <= '0;
            shift_reg <= '0;
            skip_reg  <= '0;
            ctr_reg   <= '0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            shift_reg <= shift_next;
            skip_reg  <= skip_next;
            ctr_reg   <= ctr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && slot_we)
        begin
            slot_reg[slot_idx] <= data_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept && (emit_rec || emit_end))
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && emit_rec)
        begin
            kind_reg          <= KIND_RECORD;
            min_version_reg   <= {view[1],  view[0]};
            flag_bits_reg     <= {view[3],  view[2]};
            method_reg        <= {view[5],  view[4]};
            mod_time_reg      <= {view[7],  view[6]};
            mod_date_reg      <= {view[9],  view[8]};
            crc_value_reg     <= {view[13], view[12], view[11], view[10]};
            packed_size_reg   <= {view[17], view[16], view[15], view[14]};
            plain_size_reg    <= {view[21], view[20], view[19], view[18]};
            name_len_reg      <= {view[23], view[22]};
            header_offset_reg <= {view[31], view[30], view[29], view[28]};
            record_index_reg  <= ctr_eff;
        end
        else if (accept && emit_end)
        begin
            kind_reg          <= KIND_END;
            min_version_reg   <= '0;
            flag_bits_reg     <= '0;
            method_reg        <= '0;
            mod_time_reg      <= '0;
            mod_date_reg      <= '0;
            crc_value_reg     <= '0;
            packed_size_reg   <= '0;
            plain_size_reg    <= '0;
            name_len_reg      <= '0;
            header_offset_reg <= '0;
            record_index_reg  <= ctr_eff;
        end
    end

    assign out_valid     = out_valid_reg;
    assign kind          = kind_reg;
    assign min_version   = min_version_reg;
    assign flag_bits     = flag_bits_reg;
    assign method        = method_reg;
    assign mod_time      = mod_time_reg;
    assign mod_date      = mod_date_reg;
    assign crc_value     = crc_value_reg;
    assign packed_size   = packed_size_reg;
    assign plain_size    = plain_size_reg;
    assign name_len      = name_len_reg;
    assign header_offset = header_offset_reg;
    assign record_index  = record_index_reg;

endmodule

// File: src/zcdp_checker.sv
module zcdp_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic        kind,
    input logic [15:0] min_version,
    input logic [15:0] flag_bits,
    input logic [15:0] method,
    input logic [15:0] mod_time,
    input logic [15:0] mod_date,
    input logic [31:0] crc_value,
    input logic [31:0] packed_size,
    input logic [31:0] plain_size,
    input logic [15:0] name_len,
    input logic [31:0] header_offset,
    input logic [15:0] record_index
);
    import zcdp_pkg::*;

    // a stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(record_index)
            && $stable(crc_value) && $stable(header_offset))
        else $error("output word changed while stalled");

    // an end word carries nothing but the record count
    a_end_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_END |-> min_version == '0 && flag_bits == '0
            && method == '0 && mod_time == '0 && mod_date == '0 && crc_value == '0
            && packed_size == '0 && plain_size == '0 && name_len == '0
            && header_offset == '0)
        else $error("end word has nonzero record fields");

    // a new result needs an input byte taken the cycle before
    a_out_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready))
        else $error("result appeared without an accepted byte");

    // the parser never refuses input while the output side is free
    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty output");

endmodule

bind zip_central_directory_parser zcdp_checker u_zcdp_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .kind          (kind),
    .min_version   (min_version),
    .flag_bits     (flag_bits),
    .method        (method),
    .mod_time      (mod_time),
    .mod_date      (mod_date),
    .crc_value     (crc_value),
    .packed_size   (packed_size),
    .plain_size    (plain_size),
    .name_len      (name_len),
    .header_offset (header_offset),
    .record_index  (record_index)
);

// File: dv/zip_central_directory_parser_test.sv
`timescale 1ns / 100ps

module zip_central_directory_parser_test;

    import zcdp_pkg::*;

    localparam int ITEMS     = 1950;
    localparam int LIMIT     = 3_000_000;
    localparam int DRAIN_CYC = 20;

    typedef struct {
        logic [7:0] data;
        logic       restart;
        int         gap;
        bit         drain;
    } dir_byte_t;

    typedef struct packed {
        kind_t       kind;
        logic [15:0] min_version;
        logic [15:0] flag_bits;
        logic [15:0] method;
        logic [15:0] mod_time;
        logic [15:0] mod_date;
        logic [31:0] crc_value;
        logic [31:0] packed_size;
        logic [31:0] plain_size;
        logic [15:0] name_len;
        logic [31:0] header_offset;
        logic [15:0] record_index;
    } summary_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  data_byte = 8'h00;
    logic        restart = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic        kind;
    logic [15:0] min_version;
    logic [15:0] flag_bits;
    logic [15:0] method;
    logic [15:0] mod_time;
    logic [15:0] mod_date;
    logic [31:0] crc_value;
    logic [31:0] packed_size;
    logic [31:0] plain_size;
    logic [15:0] name_len;
    logic [31:0] header_offset;
    logic [15:0] record_index;

    zip_central_directory_parser u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .data_byte     (data_byte),
        .restart       (restart),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .kind          (kind),
        .min_version   (min_version),
        .flag_bits     (flag_bits),
        .method        (method),
        .mod_time      (mod_time),
        .mod_date      (mod_date),
        .crc_value     (crc_value),
        .packed_size   (packed_size),
        .plain_size    (plain_size),
        .name_len      (name_len),
        .header_offset (header_offset),
        .record_index  (record_index)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    dir_byte_t byte_stream[$];
    summary_t  summaries_due[$];
    int        errors = 0;
    int        cycles = 0;
    int        stream_count = 0;
    bit        calm = 0;
    bit        drain_next = 0;
    bit        need_restart = 0;
    bit        steady_rx = 0;
    logic      byte_taken = 1'b0;
    int        idle_left = 0;
    int        stall_left = 0;

    // parser shadow
    phase_t      cd_phase = PH_SIG;
    logic [5:0]  cd_count = '0;
    logic [31:0] cd_sig = '0;
    logic [7:0]  cd_fixed [FIXED_LEN];
    logic [17:0] cd_skip = '0;
    logic [15:0] cd_records = '0;

    function automatic logic [15:0] le16(int at);
        return {cd_fixed[at + 1], cd_fixed[at]};
    endfunction

    function automatic logic [31:0] le32(int at);
        return {le16(at + 2), le16(at)};
    endfunction

    task automatic close_record();
        summary_t s;
        s.kind          = KIND_RECORD;
        s.min_version   = le16(2);
        s.flag_bits     = le16(4);
        s.method        = le16(6);
        s.mod_time      = le16(8);
        s.mod_date      = le16(10);
        s.crc_value     = le32(12);
        s.packed_size   = le32(16);
        s.plain_size    = le32(20);
        s.name_len      = le16(24);
        s.header_offset = le32(38);
        s.record_index  = cd_records;
        summaries_due = {summaries_due, s};
        if (cd_records != 16'hFFFF)
            cd_records++;
        cd_phase = PH_SIG;
        cd_count = '0;
        cd_sig   = '0;
    endtask

    task automatic parse_byte(input logic [7:0] b, input logic rs);
        summary_t    s;
        logic [17:0] total;
        if (rs)
        begin
            cd_phase   = PH_SIG;
            cd_count   = '0;
            cd_sig     = '0;
            cd_skip    = '0;
            cd_records = '0;
        end
        case (cd_phase)
            PH_SIG:
            begin
                cd_sig = {b, cd_sig[31:8]};
                cd_count++;
                if (cd_count == SIG_LEN)
                begin
                    cd_count = '0;
                    if (cd_sig == DIR_SIGNATURE)
                        cd_phase = PH_FIXED;
                    else
                    begin
                        cd_phase       = PH_END;
                        s              = '0;
                        s.kind         = KIND_END;
                        s.record_index = cd_records;
                        summaries_due = {summaries_due, s};
                    end
                end
            end
            PH_FIXED:
            begin
                cd_fixed[cd_count] = b;
                cd_count++;
                if (cd_count == FIXED_LEN)
                begin
                    cd_count = '0;
                    total = le16(24) + le16(26) + le16(28);
                    if (total == 0)
                        close_record();
                    else
                    begin
                        cd_skip  = total;
                        cd_phase = PH_SKIP;
                    end
                end
            end
            PH_SKIP:
            begin
                if (cd_skip != 0)
                    cd_skip--;
                if (cd_skip == 0)
                    close_record();
            end
            default: ;
        endcase
    endtask

    // mostly short, a few long; none at all in quiet stretches
    function automatic int pick_gap(bit quiet);
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [15:0] rand_len();
        int r;
        r = $urandom_range(0, 9);
        if (r < 4)
            return 16'd0;
        if (r < 8)
            return 16'($urandom_range(1, 4));
        return 16'($urandom_range(5, 24));
    endfunction

    function automatic logic [335:0] random_fixed(logic [15:0] nlen, logic [15:0] xlen,
                                                  logic [15:0] clen);
        logic [335:0] fx;
        for (int k = 0; k < FIXED_LEN; k++)
            fx[8*k +: 8] = 8'($urandom_range(0, 255));
        fx[24*8 +: 16] = nlen;
        fx[26*8 +: 16] = xlen;
        fx[28*8 +: 16] = clen;
        return fx;
    endfunction

    task automatic put_byte(input logic [7:0] b, input logic rs, input bit counts);
        dir_byte_t w;
        w.data    = b;
        w.restart = rs;
        w.gap     = pick_gap(calm);
        w.drain   = drain_next;
        drain_next = 0;
        byte_stream = {byte_stream, w};
        if (counts)
            stream_count++;
    endtask

    task automatic put_sig(input logic [31:0] sig, input logic rs);
        for (int k = 0; k < SIG_LEN; k++)
            put_byte(sig[8*k +: 8], rs && k == 0, 1);
    endtask

    // whole record, or only its first cut bytes when cut >= 0
    task automatic put_record(input logic [335:0] fx, input logic rs, input int cut);
        logic [7:0]  seq[$];
        logic [17:0] skip;
        int          n;
        skip = fx[24*8 +: 16] + fx[26*8 +: 16] + fx[28*8 +: 16];
        for (int k = 0; k < SIG_LEN; k++)
            seq = {seq, DIR_SIGNATURE[8*k +: 8]};
        for (int k = 0; k < FIXED_LEN; k++)
            seq = {seq, fx[8*k +: 8]};
        for (int k = 0; k < skip; k++)
            seq = {seq, 8'($urandom_range(0, 255))};
        n = (cut >= 0 && cut < seq.size()) ? cut : seq.size();
        for (int k = 0; k < n; k++)
            put_byte(seq[k], rs && k == 0, 1);
    endtask

    task automatic put_end(input logic rs);
        logic [31:0] bad;
        int          m;
        if ($urandom_range(0, 1) == 0)
            bad = DIR_SIGNATURE ^ (32'd1 << $urandom_range(0, 31));
        else
            bad = $urandom;
        if (bad == DIR_SIGNATURE)
            bad[0] = ~bad[0];
        put_sig(bad, rs);
        // dropped by the block until a restart
        m = $urandom_range(0, 6);
        for (int k = 0; k < m; k++)
            put_byte(8'($urandom_range(0, 255)), 1'b0, 0);
    endtask

    task automatic check_field(input string fname, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
        begin
            errors++;
            if (errors <= 10)
                $display("%0t: %s mismatch: expected %h, got %h", $realtime, fname, want, got);
        end
    endtask

    // sender: new word at the falling edge
    always @(negedge clk)
    begin
        dir_byte_t w;
        if (rst_n && (!in_valid || byte_taken))
        begin
            if (idle_left > 0)
            begin
                in_valid <= 1'b0;
                idle_left--;
            end
            else if (byte_stream.size() == 0 ||
                     (byte_stream[0].drain && summaries_due.size() != 0))
                in_valid <= 1'b0;
            else
            begin
                w = byte_stream.pop_front();
                in_valid  <= 1'b1;
                data_byte <= w.data;
                restart   <= w.restart;
                idle_left = (byte_stream.size() != 0) ? byte_stream[0].gap : 0;
            end
        end
    end

    // receiver stalls
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if ($urandom_range(0, 299) == 0)
                steady_rx = !steady_rx;
            if (stall_left > 0)
            begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                out_ready <= 1'b1;
                stall_left = pick_gap(steady_rx);
            end
        end
    end

    // monitor: check the outgoing word first, then predict from the incoming one
    always @(posedge clk)
    begin
        summary_t got;
        summary_t want;
        if (rst_n)
        begin
            byte_taken <= in_valid && in_ready;
            if (out_valid && out_ready)
            begin
                got = {kind, min_version, flag_bits, method, mod_time, mod_date, crc_value,
                       packed_size, plain_size, name_len, header_offset, record_index};
                if (summaries_due.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("%0t: unexpected word, kind %0d index %0d",
                                 $realtime, kind, record_index);
                end
                else
                begin
                    want = summaries_due.pop_front();
                    check_field("kind", 32'(got.kind), 32'(want.kind));
                    check_field("min_version", 32'(got.min_version), 32'(want.min_version));
                    check_field("flag_bits", 32'(got.flag_bits), 32'(want.flag_bits));
                    check_field("method", 32'(got.method), 32'(want.method));
                    check_field("mod_time", 32'(got.mod_time), 32'(want.mod_time));
                    check_field("mod_date", 32'(got.mod_date), 32'(want.mod_date));
                    check_field("crc_value", got.crc_value, want.crc_value);
                    check_field("packed_size", got.packed_size, want.packed_size);
                    check_field("plain_size", got.plain_size, want.plain_size);
                    check_field("name_len", 32'(got.name_len), 32'(want.name_len));
                    check_field("header_offset", got.header_offset, want.header_offset);
                    check_field("record_index", 32'(got.record_index),
                                32'(want.record_index));
                end
            end
            if (in_valid && in_ready)
                parse_byte(data_byte, restart);
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles == LIMIT)
        begin
            $display("[zip_central_directory_parser] ERROR");
            $finish;
        end
    end

    initial
    begin
        int          random_start;
        int          n;
        logic        rs;
        logic [335:0] fx;

        // empty variable part, all-zero fields
        put_record('0, 1'b0, -1);
        drain_next = 1;
        put_record(random_fixed(16'd3, 16'd2, 16'd1), 1'b0, -1);
        put_record(random_fixed(16'd0, 16'd0, 16'd1), 1'b0, -1);
        put_record(random_fixed(16'd0, 16'd1, 16'd0), 1'b0, -1);
        put_record(random_fixed(16'd1, 16'd0, 16'd0), 1'b0, -1);
        // every other field all ones, short variable part
        calm = 1;
        fx = '1;
        fx[24*8 +: 48] = {16'd0, 16'd1, 16'd2};
        put_record(fx, 1'b0, -1);
        calm = 0;
        put_end(1'b0);
        drain_next = 1;
        put_record(random_fixed(16'd2, 16'd0, 16'd0), 1'b1, -1);
        // restart in the fixed part, in the skip part and in the signature
        put_record(random_fixed(16'd0, 16'd0, 16'd0), 1'b0, 20);
        put_record(random_fixed(16'd0, 16'd0, 16'd0), 1'b1, -1);
        put_record(random_fixed(16'd5, 16'd0, 16'd0), 1'b0, 48);
        put_record(random_fixed(16'd0, 16'd0, 16'd2), 1'b1, -1);
        put_record(random_fixed(16'd0, 16'd0, 16'd0), 1'b0, 2);
        put_end(1'b1);
        need_restart = 1;

        random_start = stream_count;
        while (stream_count < random_start + ITEMS)
        begin
            calm       = ($urandom_range(0, 4) == 0);
            drain_next = ($urandom_range(0, 9) == 0);
            n = $urandom_range(0, 6);
            for (int r = 0; r < n; r++)
            begin
                rs = need_restart || ($urandom_range(0, 9) == 0);
                fx = random_fixed(rand_len(), rand_len(), rand_len());
                if ($urandom_range(0, 14) == 0)
                begin
                    put_record(fx, rs, $urandom_range(1, 46));
                    need_restart = 1;
                end
                else
                begin
                    put_record(fx, rs, -1);
                    need_restart = 0;
                end
            end
            if ($urandom_range(0, 2) == 0)
            begin
                put_end(need_restart);
                need_restart = 1;
            end
        end

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // in_valid drops only after the last byte has been taken
        while (byte_stream.size() != 0 || in_valid)
            @(posedge clk);
        while (summaries_due.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYC) @(negedge clk);

        if (errors == 0 && summaries_due.size() == 0)
            $display("[zip_central_directory_parser] OK");
        else
            $display("[zip_central_directory_parser] ERROR");
        $finish;
    end

endmodule

// File: zip_central_directory_parser.f
src/zcdp_pkg.sv
src/zip_central_directory_parser.sv
src/zcdp_checker.sv
dv/zip_central_directory_parser_test.sv
